/* sv/srbr_pkg.sv */
// ----------------------------------------------------------------------------
// srbr_pkg: shared constants and types of the skip-ring broadcast router
// Rank and channel sizes, configuration register indexes, and the command
// and status groups passed between the controller and the datapath.
// ----------------------------------------------------------------------------
package srbr_pkg;

  localparam int RANK_BITS    = 10;
  localparam int MAX_CHANNELS = 10;

  // Ring size and wall rank need one bit more than a rank.
  localparam int WS_W   = RANK_BITS + 1;
  // Table index and node level.
  localparam int CH_W   = $clog2(MAX_CHANNELS);
  // Raw bit position inside a ring-size word.
  localparam int LOG_W  = $clog2(RANK_BITS + 1);
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_NODE_RANK  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_WORLD_SIZE = CFG_IDX_W'(1);

  typedef struct packed {
    logic init;        // latch level, wall and count, restart table index
    logic table_step;  // write one destination table entry
    logic capture;     // latch an accepted input beat
    logic build;       // build the send mask for the captured item
    logic emit;        // load the output register with the next destination
  } cmd_t;

  typedef struct packed {
    logic cfg_wr;      // a register write lands this cycle
    logic table_done;  // the current table entry is the last one
    logic mask_none;   // the item being built sends nothing
    logic last_pick;   // the destination being emitted is the final one
    logic out_free;    // the output register can take a new beat
  } stat_t;

endpackage

/* sv/skip_ring_bcast_router.sv */
// ----------------------------------------------------------------------------
// skip_ring_bcast_router: forwarding decision of a skip-ring broadcast node
// Derives the node's destination table from its rank and the ring size and
// emits the destinations of each originate or forward item, furthest first.
// ----------------------------------------------------------------------------
// Flow: an accepted input beat is captured, its send mask is built, and its
// first destination is loaded into the output register; one destination
// follows per cycle after that while out_stall is low. No new input beat
// is accepted until the last destination of the item has been loaded.
// Reset and every register write start a table derivation during which
// no input beat is accepted.
// ----------------------------------------------------------------------------
module skip_ring_bcast_router
  import srbr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_op,
  input  logic [RANK_BITS-1:0] in_source_rank,
  input  logic [RANK_BITS-1:0] in_origin_rank,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [RANK_BITS-1:0] out_dest_rank,
  output logic                 out_last_dest,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WS_W-1:0]      cfg_data
);

  cmd_t  cmd;
  stat_t stat;

  srbr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  srbr_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_op          (in_op),
    .in_source_rank (in_source_rank),
    .in_origin_rank (in_origin_rank),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_dest_rank  (out_dest_rank),
    .out_last_dest  (out_last_dest),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

endmodule

/* sv/srbr_ctrl.sv */
// ----------------------------------------------------------------------------
// srbr_ctrl: sequencing of the skip-ring broadcast router
// Runs the table derivation after reset and after register writes, then
// takes one item at a time and walks its destinations out.
// ----------------------------------------------------------------------------
module srbr_ctrl
  import srbr_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_stall,
  input  stat_t stat,
  output cmd_t  cmd
);

  localparam logic [2:0] ST_INIT   = 3'd0;
  localparam logic [2:0] ST_DERIVE = 3'd1;
  localparam logic [2:0] ST_IDLE   = 3'd2;
  localparam logic [2:0] ST_LOAD   = 3'd3;
  localparam logic [2:0] ST_EMIT   = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_INIT: begin
        cmd.init  = 1'b1;
        state_nxt = ST_DERIVE;
      end
      ST_DERIVE: begin
        cmd.table_step = 1'b1;
        if (stat.table_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd.build = 1'b1;
        state_nxt = stat.mask_none ? ST_IDLE : ST_EMIT;
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (stat.last_pick) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_INIT;
      end
    endcase
    // A register write always restarts the derivation.
    if (stat.cfg_wr) begin
      state_nxt = ST_INIT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != ST_IDLE);

endmodule

/* sv/srbr_dp.sv */
// ----------------------------------------------------------------------------
// srbr_dp: datapath of the skip-ring broadcast router
// Holds the configuration, the derived level, wall and destination table,
// the captured item with its send mask, and the output register.
// ----------------------------------------------------------------------------
module srbr_dp
  import srbr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  cmd_t                 cmd,
  output stat_t                stat,
  input  logic                 in_op,
  input  logic [RANK_BITS-1:0] in_source_rank,
  input  logic [RANK_BITS-1:0] in_origin_rank,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [RANK_BITS-1:0] out_dest_rank,
  output logic                 out_last_dest,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WS_W-1:0]      cfg_data
);

  localparam logic [WS_W-1:0] WS_MIN = WS_W'(2);
  localparam logic [WS_W-1:0] WS_MAX = WS_W'(1) << RANK_BITS;

  function automatic logic [LOG_W-1:0] msb_pos(input logic [WS_W-1:0] v);
    logic [LOG_W-1:0] p;
    p = '0;
    for (int i = 0; i < WS_W; i++) begin
      if (v[i]) p = LOG_W'(i);
    end
    return p;
  endfunction

  function automatic logic [LOG_W-1:0] lsb_pos(input logic [RANK_BITS-1:0] v);
    logic [LOG_W-1:0] p;
    p = '0;
    for (int i = RANK_BITS - 1; i >= 0; i--) begin
      if (v[i]) p = LOG_W'(i);
    end
    return p;
  endfunction

  // True when the destination lies on the part of the ring that the
  // message has already covered since it left its origin.
  function automatic logic passed_origin(input logic [RANK_BITS-1:0] origin,
                                         input logic [RANK_BITS-1:0] dest,
                                         input logic [RANK_BITS-1:0] me);
    logic res;
    if (dest == origin) begin
      res = 1'b1;
    end else if (me >= origin) begin
      res = (dest <= me) && (dest >= origin);
    end else begin
      res = !((dest > me) && (dest < origin));
    end
    return res;
  endfunction

  logic [RANK_BITS-1:0]    node_rank_r;
  logic [WS_W-1:0]         world_size_r;
  logic [CH_W-1:0]         node_level_r;
  logic [WS_W-1:0]         wall_rank_r;
  logic [CH_W-1:0]         channel_count_r;
  logic [RANK_BITS-1:0]    dest_table_r [MAX_CHANNELS];
  logic [CH_W-1:0]         idx_r;
  logic                    op_r;
  logic [RANK_BITS-1:0]    src_r;
  logic [RANK_BITS-1:0]    origin_r;
  logic [MAX_CHANNELS-1:0] mask_r;
  logic                    out_valid_r;
  logic [RANK_BITS-1:0]    out_dest_r;
  logic                    out_last_r;

  logic                    cfg_wr;
  logic [WS_W-1:0]         ws_eff;
  logic                    ws_pow2;
  logic [LOG_W-1:0]        lvl_raw;
  logic [CH_W-1:0]         lvl;
  logic [WS_W-1:0]         wall_calc;
  logic [WS_W-1:0]         dest_sum;
  logic                    dest_over;
  logic [RANK_BITS-1:0]    dest_val;
  logic                    mode_all;
  logic                    mode_filt;
  logic [MAX_CHANNELS-1:0] mask_calc;
  logic [CH_W-1:0]         pick;
  logic [MAX_CHANNELS-1:0] mask_rest;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid &&
                     (cfg_index == CFG_NODE_RANK || cfg_index == CFG_WORLD_SIZE);

  // Effective ring size and the derived level and wall of this node.
  always_comb begin
    if (world_size_r < WS_MIN) begin
      ws_eff = WS_MIN;
    end else if (world_size_r > WS_MAX) begin
      ws_eff = WS_MAX;
    end else begin
      ws_eff = world_size_r;
    end
    ws_pow2 = ((ws_eff & (ws_eff - WS_W'(1))) == '0);
    // Rank 0 sits at the level of the highest bit of ring size minus one;
    // other ranks at the count of their trailing zeros.
    lvl_raw = (node_rank_r == '0) ? msb_pos(ws_eff - WS_W'(1)) : lsb_pos(node_rank_r);
    if (int'(lvl_raw) > MAX_CHANNELS - 1) begin
      lvl = CH_W'(MAX_CHANNELS - 1);
    end else begin
      lvl = CH_W'(lvl_raw);
    end
    if (node_rank_r == '0) begin
      wall_calc = WS_W'(1) << lvl;
    end else begin
      wall_calc = WS_W'(node_rank_r & (node_rank_r - RANK_BITS'(1)));
    end
  end

  // One table entry per cycle during derivation.
  always_comb begin
    dest_sum  = WS_W'(node_rank_r) + (WS_W'(1) << idx_r);
    dest_over = !ws_pow2 && (dest_sum >= ws_eff);
    if (ws_pow2) begin
      dest_val = RANK_BITS'(dest_sum & (ws_eff - WS_W'(1)));
    end else if (dest_over) begin
      dest_val = '0;
    end else begin
      dest_val = RANK_BITS'(dest_sum);
    end
  end

  // Send mask of the captured item over all table entries.
  always_comb begin
    mode_all  = op_r || ((node_level_r != '0) && (WS_W'(src_r) > wall_rank_r));
    mode_filt = (node_level_r != '0);
    for (int j = 0; j < MAX_CHANNELS; j++) begin
      if (mode_all) begin
        mask_calc[j] = (CH_W'(j) <= channel_count_r);
      end else if (mode_filt) begin
        mask_calc[j] = (CH_W'(j) < channel_count_r) &&
                       !passed_origin(origin_r, dest_table_r[j], node_rank_r);
      end else begin
        mask_calc[j] = 1'b0;
      end
    end
  end

  // Furthest remaining destination goes first.
  always_comb begin
    pick = '0;
    for (int j = 0; j < MAX_CHANNELS; j++) begin
      if (mask_r[j]) pick = CH_W'(j);
    end
    mask_rest = mask_r & ~(MAX_CHANNELS'(1) << pick);
  end

  always_comb begin
    stat.cfg_wr     = cfg_wr;
    stat.table_done = dest_over || (idx_r == node_level_r);
    stat.mask_none  = (mask_calc == '0);
    stat.last_pick  = (mask_rest == '0);
    stat.out_free   = !out_valid_r || !out_stall;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_rank_r     <= '0;
      world_size_r    <= WS_MIN;
      node_level_r    <= '0;
      wall_rank_r     <= '0;
      channel_count_r <= '0;
      idx_r           <= '0;
      mask_r          <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      if (cfg_wr) begin
        if (cfg_index == CFG_NODE_RANK) begin
          node_rank_r <= cfg_data[RANK_BITS-1:0];
        end else begin
          world_size_r <= cfg_data;
        end
      end
      if (cmd.init) begin
        node_level_r    <= lvl;
        wall_rank_r     <= wall_calc;
        channel_count_r <= lvl;
        idx_r           <= '0;
      end
      if (cmd.table_step) begin
        idx_r <= idx_r + CH_W'(1);
        if (dest_over) begin
          channel_count_r <= idx_r;
        end
      end
      if (cmd.build) begin
        mask_r <= mask_calc;
      end else if (cmd.emit) begin
        mask_r <= mask_rest;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.table_step) begin
      dest_table_r[idx_r] <= dest_val;
    end
    if (cmd.capture) begin
      op_r     <= in_op;
      src_r    <= in_source_rank;
      origin_r <= in_origin_rank;
    end
    if (cmd.emit) begin
      out_dest_r <= dest_table_r[pick];
      out_last_r <= stat.last_pick;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_dest_rank = out_dest_r;
  assign out_last_dest = out_last_r;

endmodule
